>>> rtl/brle_pkg.sv
package brle_pkg;

    // Run count saturates here; an equal symbol at this count closes the run.
    localparam logic [7:0] RUN_MAX = 8'd255;

    localparam int BITS_PER_BYTE = 8;
    localparam int IDX_W = $clog2(BITS_PER_BYTE);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BITS_PER_BYTE - 1);

    // Symbol mode codes.
    localparam logic MODE_BIT  = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] run_value;
        logic [7:0] run_count;
        logic       item_last;
        logic       stream_last;
    } out_item_t;

    // One queued byte together with what the front end worked out for it.
    typedef struct packed {
        in_item_t                 item;
        logic                     symbol_mode;
        logic [BITS_PER_BYTE-1:0] more_mask;
    } q_entry_t;

endpackage

>>> rtl/brle_front.sv
module brle_front
    import brle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data,
    input  logic     q_full,
    output logic     q_push,
    output q_entry_t q_push_entry
);

    logic                     symbol_mode_reg;
    logic                     symbol_mode_next;
    logic [BITS_PER_BYTE-1:0] more_mask;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign q_push    = in_valid && in_ready;

    always_comb
    begin
        symbol_mode_next = symbol_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            symbol_mode_next = cfg_data;
        end
    end

    // Bit i of the mask tells whether a run closed at bit position i is
    // followed by another close later in the same byte, which happens
    // exactly when bits i up to the top are not all equal.
    always_comb
    begin
        more_mask[BITS_PER_BYTE-1] = 1'b0;
        for (int i = BITS_PER_BYTE - 2; i >= 0; i--)
        begin
            more_mask[i] = more_mask[i+1] | (in_data.data_byte[i] ^ in_data.data_byte[i+1]);
        end
    end

    always_comb
    begin
        q_push_entry.item        = in_data;
        q_push_entry.symbol_mode = symbol_mode_reg;
        q_push_entry.more_mask   = more_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_mode_reg <= MODE_BIT;
        end
        else
        begin
            symbol_mode_reg <= symbol_mode_next;
        end
    end

endmodule

>>> rtl/brle_queue.sv
module brle_queue
    import brle_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t             mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/brle_back.sv
module brle_back
    import brle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  q_entry_t  q_entry,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [7:0]       open_sym_reg;
    logic [7:0]       open_sym_next;
    logic [7:0]       open_cnt_reg;
    logic [7:0]       open_cnt_next;
    logic             run_open_reg;
    logic             run_open_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             flush_reg;
    logic             flush_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;

    logic             can_emit;
    logic             step;
    logic             byte_mode;
    logic             item_end;
    logic [7:0]       sym;
    logic             last_sym;
    logic             closes;
    logic             extend;
    logic [7:0]       new_sym;
    logic [7:0]       new_cnt;
    logic             close_item_last;
    logic             emit;
    out_item_t        emit_data;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        can_emit  = !out_valid_reg || out_ready;
        step      = q_valid && can_emit;
        byte_mode = (q_entry.symbol_mode == MODE_BYTE);
        item_end  = q_entry.item.stream_end;
        sym       = byte_mode ? q_entry.item.data_byte
                              : {7'b0, q_entry.item.data_byte[idx_reg]};
        last_sym  = byte_mode || (idx_reg == IDX_LAST);
        closes    = run_open_reg && ((sym != open_sym_reg) || (open_cnt_reg == RUN_MAX));
        extend    = run_open_reg && !closes;
        new_sym   = extend ? open_sym_reg : sym;
        new_cnt   = extend ? open_cnt_reg + 8'd1 : 8'd1;
        // A closed run is the byte's last pair unless a flush or a later
        // close in the same byte follows it.
        close_item_last = !item_end && (byte_mode || !q_entry.more_mask[idx_reg]);
    end

    always_comb
    begin
        open_sym_next = open_sym_reg;
        open_cnt_next = open_cnt_reg;
        run_open_next = run_open_reg;
        idx_next      = idx_reg;
        flush_next    = flush_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        emit_data     = '0;

        if (step)
        begin
            if (flush_reg)
            begin
                emit          = 1'b1;
                emit_data     = '{open_sym_reg, open_cnt_reg, 1'b1, 1'b1};
                open_sym_next = '0;
                open_cnt_next = '0;
                run_open_next = 1'b0;
                flush_next    = 1'b0;
                idx_next      = '0;
                q_pop         = 1'b1;
            end
            else
            begin
                open_sym_next = new_sym;
                open_cnt_next = new_cnt;
                run_open_next = 1'b1;
                if (closes)
                begin
                    emit      = 1'b1;
                    emit_data = '{open_sym_reg, open_cnt_reg, close_item_last, 1'b0};
                end
                if (last_sym)
                begin
                    idx_next = '0;
                    if (item_end)
                    begin
                        if (closes)
                        begin
                            // The flush pair is sent later, on its own, from the flush state.
                            flush_next = 1'b1;
                        end
                        else
                        begin
                            emit          = 1'b1;
                            emit_data     = '{new_sym, new_cnt, 1'b1, 1'b1};
                            open_sym_next = '0;
                            open_cnt_next = '0;
                            run_open_next = 1'b0;
                            q_pop         = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_sym_reg  <= '0;
            open_cnt_reg  <= '0;
            run_open_reg  <= 1'b0;
            idx_reg       <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_sym_reg  <= open_sym_next;
            open_cnt_reg  <= open_cnt_next;
            run_open_reg  <= run_open_next;
            idx_reg       <= idx_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/bit_run_length_encoder_core.sv
// Run-length encoder that turns a byte stream into (value, count) pairs,
// with counts capped at 255. In bit mode (symbol_mode = 0) each byte is
// taken as eight 0/1 symbols, least significant bit first; in byte mode
// (symbol_mode = 1) each byte is one symbol. The byte flagged stream_end
// flushes the open run as the final pair, marked stream_last, and the
// encoder returns to empty. Every byte's last pair carries item_last; a
// byte that closes no run and does not end the stream yields no pair.
// A front end takes one input transaction per cycle, while the queue has
// room, into a small queue (QUEUE_DEPTH entries); the back end walks one
// symbol per cycle and sends at most one pair per cycle through a registered
// output. A stream_end byte whose last symbol also closes a run sends its
// final pair from a separate flush step after that symbol.
// Output stalls hold the back end only while the output register is full
// and not taken; the queue accepts input until full. Write symbol_mode only
// while the encoder is idle; it applies from the next byte accepted.
module bit_run_length_encoder_core
    import brle_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    // Front end to queue.
    logic     q_full;
    logic     q_push;
    q_entry_t q_push_entry;

    // Queue to back end.
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_head;

    // The front end holds the mode register, tags each accepted byte with
    // the current mode and precomputes where later runs close in the byte.
    brle_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_entry (q_push_entry)
    );

    // The queue decouples input acceptance from symbol processing.
    brle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    // The back end owns the open run and produces the pairs.
    brle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> tb/brle_scoreboard_pkg.sv
package brle_scoreboard_pkg;

    import brle_pkg::*;

    // Tracks the open run the same way the encoder does and queues the pairs
    // that each accepted byte must produce.
    class run_pair_scoreboard;

        logic        symbol_mode;
        logic [7:0]  open_symbol;
        logic [7:0]  open_count;
        bit          run_open;
        out_item_t   byte_pairs[$];
        out_item_t   pending_pairs[$];
        int unsigned mismatches;

        function new();
            symbol_mode = MODE_BIT;
            open_symbol = '0;
            open_count  = '0;
            run_open    = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_mode(logic mode);
            symbol_mode = mode;
        endfunction

        // Folds one symbol into the open run. A run that ends, either on a new
        // symbol or at the count cap, is queued as a pair of this byte.
        function void add_symbol(logic [7:0] sym);
            out_item_t pair;
            if (!run_open)
            begin
                run_open    = 1'b1;
                open_symbol = sym;
                open_count  = 8'd1;
            end
            else if (sym == open_symbol && open_count != RUN_MAX)
            begin
                open_count = open_count + 8'd1;
            end
            else
            begin
                pair.run_value   = open_symbol;
                pair.run_count   = open_count;
                pair.item_last   = 1'b0;
                pair.stream_last = 1'b0;
                byte_pairs       = {byte_pairs, pair};
                open_symbol = sym;
                open_count  = 8'd1;
            end
        endfunction

        function void note_byte(in_item_t item);
            out_item_t pair;
            int        i;
            byte_pairs.delete();
            if (symbol_mode == MODE_BYTE)
            begin
                add_symbol(item.data_byte);
            end
            else
            begin
                for (i = 0; i < BITS_PER_BYTE; i++)
                    add_symbol({7'd0, item.data_byte[i]});
            end
            if (item.stream_end && run_open)
            begin
                pair.run_value   = open_symbol;
                pair.run_count   = open_count;
                pair.item_last   = 1'b0;
                pair.stream_last = 1'b1;
                byte_pairs       = {byte_pairs, pair};
                run_open    = 1'b0;
                open_symbol = '0;
                open_count  = '0;
            end
            foreach (byte_pairs[k])
            begin
                pair = byte_pairs[k];
                pair.item_last = (k == byte_pairs.size() - 1);
                pending_pairs  = {pending_pairs, pair};
            end
        endfunction

        function void check_pair(out_item_t got);
            out_item_t want;
            if (pending_pairs.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no pair, actual value %0d count %0d",
                         $time, got.run_value, got.run_count);
                $display("%0t:     actual item_last %0b stream_last %0b",
                         $time, got.item_last, got.stream_last);
                return;
            end
            want = pending_pairs.pop_front();
            if (got.run_value !== want.run_value)
            begin
                mismatches++;
                $display("%0t: run_value expected %0d, actual %0d",
                         $time, want.run_value, got.run_value);
            end
            if (got.run_count !== want.run_count)
            begin
                mismatches++;
                $display("%0t: run_count expected %0d, actual %0d",
                         $time, want.run_count, got.run_count);
            end
            if (got.item_last !== want.item_last)
            begin
                mismatches++;
                $display("%0t: item_last expected %0b, actual %0b",
                         $time, want.item_last, got.item_last);
            end
            if (got.stream_last !== want.stream_last)
            begin
                mismatches++;
                $display("%0t: stream_last expected %0b, actual %0b",
                         $time, want.stream_last, got.stream_last);
            end
        endfunction

        function int unsigned outstanding();
            return pending_pairs.size();
        endfunction

    endclass

endpackage

>>> tb/testbench.sv
module testbench;

    import brle_pkg::*;
    import brle_scoreboard_pkg::*;

    // Number of bytes in the randomized part of the run.
    localparam int unsigned RANDOM_BYTES = 260;
    // Enough quiet cycles for the back end to finish its current byte and the
    // two bytes that the input queue holds, after which the encoder is idle.
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // Content styles for generated streams.
    localparam int STYLE_NOISE = 0;
    localparam int STYLE_FLAT  = 1;
    localparam int STYLE_PAIR  = 2;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = MODE_BIT;

    run_pair_scoreboard sb;
    int unsigned        bytes_sent  = 0;
    int unsigned        cycle_count = 0;
    // When set, the sender pushes bytes back to back with no gaps.
    bit                 quiet       = 1'b0;

    bit_run_length_encoder_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[bit_run_length_encoder_core] ERROR");
            $finish;
        end
    end

    // Every pair taken from the output is checked against the oldest pair
    // still owed. Sampling happens at the rising edge, before the encoder's
    // registers update, while the inputs were set up at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pair(out_data);
    end

    // Most gaps are zero or short; a few are long enough to back up the
    // input queue or the output register.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Output side back-pressure. Bursts of ready alternate with stalls of
    // random length, and now and then a long stretch with no stall at all.
    initial
    begin
        int unsigned span;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 4) == 0)
                span = 60;
            else
                span = $urandom_range(1, 8);
            @(negedge clk);
            out_ready <= 1'b1;
            repeat (span - 1) @(negedge clk);
            span = pick_gap();
            if (span != 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    // Sends one byte and waits for its transaction. With a zero gap valid
    // stays high, so the next byte follows without a bubble.
    task automatic send_byte(input logic [7:0] value, input logic last);
        in_item_t    item;
        int unsigned gap;
        item.data_byte  = value;
        item.stream_end = last;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(item);
        bytes_sent++;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Holds the sender until every owed pair has come out, then lets the
    // back end finish any byte that closes no run.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes symbol_mode. Callers drain the encoder first.
    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_mode(mode);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sends a stream of len bytes. Flat streams repeat one byte, which in bit
    // mode with 0x00 or 0xFF builds long runs; pair streams switch between
    // two bytes now and then, giving runs in byte mode. When closes is clear
    // the stream is left open for whatever follows.
    task automatic send_stream(input int style, input int unsigned len, input bit closes);
        logic [7:0]  base;
        logic [7:0]  alt;
        logic [7:0]  value;
        int unsigned k;
        case ($urandom_range(0, 3))
            0:       base = 8'h00;
            1:       base = 8'hFF;
            default: base = 8'($urandom);
        endcase
        alt   = 8'($urandom);
        value = base;
        for (k = 0; k < len; k++)
        begin
            case (style)
                STYLE_NOISE: value = 8'($urandom);
                STYLE_PAIR:
                begin
                    if ($urandom_range(0, 3) == 0)
                        value = (value == base) ? alt : base;
                end
                default:     value = base;
            endcase
            send_byte(value, closes && (k == len - 1));
        end
    endtask

    initial
    begin
        int unsigned random_start;
        bit          saturated;
        logic        mode;
        sb = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, bit mode. Two zero bytes close nothing, so the
        // second one yields no pair; the all-ones byte then closes a run of
        // sixteen zeros. Alternating patterns close a run on every bit after the first.
        write_mode(MODE_BIT);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        // Single-byte streams at the extremes of the byte.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b1);

        // Mode change in the middle of a stream: the run of seven zeros left
        // open in bit mode carries on with whole zero bytes in byte mode.
        send_byte(8'h01, 1'b0);
        wait_drained();
        write_mode(MODE_BYTE);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // And back: a run of byte 0x01 goes on with the first bit of the next
        // byte in bit mode.
        send_byte(8'h01, 1'b0);
        wait_drained();
        write_mode(MODE_BIT);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC3, 1'b1);

        // Random part: phases with a fresh mode, each started from an idle
        // encoder. The first bit mode phase always pushes a flat stream, long
        // enough to reach the count cap when its byte is 0x00 or 0xFF.
        random_start = bytes_sent;
        saturated    = 1'b0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            wait_drained();
            mode = $urandom_range(0, 1) ? MODE_BYTE : MODE_BIT;
            write_mode(mode);
            quiet = ($urandom_range(0, 3) == 0);
            if (mode == MODE_BIT && (!saturated || $urandom_range(0, 19) == 0))
            begin
                send_stream(STYLE_FLAT, $urandom_range(33, 40), 1'b1);
                saturated = 1'b1;
            end
            repeat ($urandom_range(2, 5))
                send_stream($urandom_range(STYLE_NOISE, STYLE_PAIR),
                            $urandom_range(1, 12), 1'b1);
            if ($urandom_range(0, 2) == 0)
                send_stream($urandom_range(STYLE_NOISE, STYLE_PAIR),
                            $urandom_range(1, 4), 1'b0);
        end
        send_stream(STYLE_NOISE, 2, 1'b1);

        wait_drained();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[bit_run_length_encoder_core] OK");
        else
            $display("[bit_run_length_encoder_core] ERROR");
        $finish;
    end

endmodule
